[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of the list store.
// Needs clk_i, and for ILS_ASSERT also rst_ni, in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ILS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ILS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hw/rtl/ils_pkg.sv]
// Package of the indexed list store: sizes, request and status codes,
// item structs and the command that is broadcast to the cell row. No dependencies.
package ils_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;

  localparam int POS_W  = 7;
  localparam int WORD_W = 32;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int EXT_W  = (DATA_WIDTH > WORD_W) ? DATA_WIDTH : WORD_W;

  localparam int GRP_SIZE = 8;
  localparam int GRP_W    = 3;
  localparam int NUM_GRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

  localparam logic [WORD_W-1:0] ERR_DATA = '1;

  typedef logic [DATA_WIDTH-1:0] elem_t;

  typedef enum logic [2:0] {
    REQ_APPEND  = 3'd0,
    REQ_INSERT  = 3'd1,
    REQ_REPLACE = 3'd2,
    REQ_REMOVE  = 3'd3,
    REQ_FIND    = 3'd4,
    REQ_CLEAR   = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_MISS  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_SHIFT_UP,
    CELL_SHIFT_DOWN
  } cell_op_e;

  typedef struct packed {
    req_e                     req_type;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_e                  status;
    logic signed [WORD_W-1:0] data;
    logic [POS_W-1:0]         count;
    logic                     empty_res;
    logic                     found;
  } res_t;

  typedef struct packed {
    cell_op_e         op;
    logic [IDX_W-1:0] idx;
    elem_t            elem;
    logic [CNT_W-1:0] count;
  } cell_cmd_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
    elem_t            rd;
  } red_t;

endpackage

[hw/rtl/ils_cell.sv]
// One entry of the list: holds a value, shifts with its neighbours and
// registers its own match and read contribution. Depends on ils_pkg.
module ils_cell (
  input  logic                    clk_i,
  input  logic [ils_pkg::IDX_W-1:0] idx_i,
  input  ils_pkg::cell_cmd_t      cmd_i,
  input  ils_pkg::elem_t          left_i,
  input  ils_pkg::elem_t          right_i,
  output ils_pkg::elem_t          data_o,
  output logic                    hit_o,
  output ils_pkg::elem_t          sel_o
);
  import ils_pkg::*;

  elem_t store_q;
  logic  hit_q;
  elem_t sel_q;

  // Match and read reflect the contents before this cycle's update.
  always_ff @(posedge clk_i) begin
    hit_q <= (store_q == cmd_i.elem) && (CNT_W'(idx_i) < cmd_i.count);
    sel_q <= (idx_i == cmd_i.idx) ? store_q : '0;
    unique case (cmd_i.op)
      CELL_WRITE: begin
        if (idx_i == cmd_i.idx) store_q <= cmd_i.elem;
      end
      CELL_SHIFT_UP: begin
        if (idx_i > cmd_i.idx) begin
          store_q <= left_i;
        end else if (idx_i == cmd_i.idx) begin
          store_q <= cmd_i.elem;
        end
      end
      CELL_SHIFT_DOWN: begin
        if (idx_i >= cmd_i.idx) store_q <= right_i;
      end
      default: ;
    endcase
  end

  assign data_o = store_q;
  assign hit_o  = hit_q;
  assign sel_o  = sel_q;

endmodule

[hw/rtl/ils_reduce.sv]
// Two-level tree over the cell row, registered at the group level: first
// matching position and the OR of the read contributions. Depends on ils_pkg.
module ils_reduce (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [ils_pkg::CAPACITY-1:0] hit_i,
  input  ils_pkg::elem_t               sel_i [ils_pkg::CAPACITY],
  output ils_pkg::red_t                red_o
);
  import ils_pkg::*;

  logic             grp_any_d   [NUM_GRP];
  logic [GRP_W-1:0] grp_first_d [NUM_GRP];
  elem_t            grp_rd_d    [NUM_GRP];
  logic             grp_any_q   [NUM_GRP];
  logic [GRP_W-1:0] grp_first_q [NUM_GRP];
  elem_t            grp_rd_q    [NUM_GRP];

  for (genvar g = 0; g < NUM_GRP; g++) begin : g_grp
    always_comb begin
      grp_any_d[g]   = 1'b0;
      grp_first_d[g] = '0;
      grp_rd_d[g]    = '0;
      // Walking downwards leaves the lowest match in place.
      for (int j = GRP_SIZE - 1; j >= 0; j--) begin
        if (g * GRP_SIZE + j < CAPACITY) begin
          grp_rd_d[g] = grp_rd_d[g] | sel_i[g * GRP_SIZE + j];
          if (hit_i[g * GRP_SIZE + j]) begin
            grp_any_d[g]   = 1'b1;
            grp_first_d[g] = GRP_W'(j);
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        grp_any_q[g]   <= grp_any_d[g];
        grp_first_q[g] <= grp_first_d[g];
        grp_rd_q[g]    <= grp_rd_d[g];
      end
    end
  end

  always_comb begin
    red_o = '0;
    for (int g = NUM_GRP - 1; g >= 0; g--) begin
      red_o.rd = red_o.rd | grp_rd_q[g];
      if (grp_any_q[g]) begin
        red_o.hit = 1'b1;
        red_o.idx = IDX_W'(g * GRP_SIZE + int'(grp_first_q[g]));
      end
    end
  end

endmodule

[hw/rtl/indexed_list_store.sv]
// Top level of the indexed list store: request decode, the cell row, the
// result tree and the output register. Depends on ils_pkg, ils_cell, ils_reduce.
//
// Usage: one request item enters on in_item_i when in_valid_i is high and
// in_stall_o is low; exactly one result item leaves on out_item_o when
// out_valid_o is high and out_stall_i is low. Requests are served one at a
// time, in order.
// Timing: an accepted request passes the execute state, where the cells update
// and register their match and read contributions, the group state, where the
// first tree level (groups of eight cells) is registered, and the result state,
// where the level across groups feeds the output register. in_stall_o falls as
// the result is written, so the next request waits until then.
// Every entry from the request position upwards changes in the execute state, so
// insert and remove cost the same as any other request, whatever the position.
// Reset clears the element count and the control state; the stored values are
// not cleared, and no request can read an entry that was never written.
// When the receiver stalls, the result holds in the output register; the next
// request may still be accepted and executed, and its result waits until the
// register is free.
module indexed_list_store (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ils_pkg::req_t in_item_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ils_pkg::res_t out_item_o
);
  import ils_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_GRP,
    ST_RES
  } state_e;

  state_e           state_q;
  req_t             req_q;
  logic [CNT_W-1:0] count_q, count_d;
  status_e          pend_status_q, pend_status_d;
  logic             pend_err_q, pend_err_d;
  logic             pend_rd_q, pend_rd_d;
  logic             pend_find_q, pend_find_d;
  logic             out_valid_q;
  res_t             out_item_q;
  res_t             res;

  cell_cmd_t             cmd, cell_cmd;
  logic [CMP_W-1:0]      pos_w, cnt_w;
  logic signed [EXT_W-1:0] val_ext, rd_ext;

  elem_t                cell_data [CAPACITY];
  elem_t                sel       [CAPACITY];
  logic [CAPACITY-1:0]  hit;
  red_t                 red;

  // Decode of the held request against the current count.
  always_comb begin
    val_ext = req_q.value;
    cnt_w   = CMP_W'(count_q);
    pos_w   = (req_q.req_type == REQ_APPEND) ? cnt_w : CMP_W'(req_q.position);

    cmd.op    = CELL_HOLD;
    cmd.idx   = pos_w[IDX_W-1:0];
    cmd.elem  = val_ext[DATA_WIDTH-1:0];
    cmd.count = count_q;

    count_d       = count_q;
    pend_status_d = STAT_OK;
    pend_err_d    = 1'b0;
    pend_rd_d     = 1'b0;
    pend_find_d   = 1'b0;

    unique case (req_q.req_type)
      REQ_APPEND, REQ_INSERT: begin
        // The range check takes priority over the room check.
        if (pos_w > cnt_w) begin
          pend_status_d = STAT_RANGE;
          pend_err_d    = 1'b1;
        end else if (count_q >= CNT_W'(CAPACITY)) begin
          pend_status_d = STAT_FULL;
          pend_err_d    = 1'b1;
        end else begin
          cmd.op  = CELL_SHIFT_UP;
          count_d = count_q + CNT_W'(1);
        end
      end
      REQ_REPLACE, REQ_REMOVE: begin
        if (pos_w >= cnt_w) begin
          pend_status_d = STAT_RANGE;
          pend_err_d    = 1'b1;
        end else begin
          pend_rd_d = 1'b1;
          if (req_q.req_type == REQ_REPLACE) begin
            cmd.op = CELL_WRITE;
          end else begin
            cmd.op  = CELL_SHIFT_DOWN;
            count_d = count_q - CNT_W'(1);
          end
        end
      end
      REQ_FIND: begin
        pend_find_d = 1'b1;
      end
      REQ_CLEAR: begin
        count_d = '0;
      end
      default: ;
    endcase

    cell_cmd = cmd;
    if (state_q != ST_EXEC) cell_cmd.op = CELL_HOLD;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    elem_t left_w, right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid
      assign left_w = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = cell_data[i+1];
    end

    ils_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(i)),
      .cmd_i   (cell_cmd),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[i]),
      .hit_o   (hit[i]),
      .sel_o   (sel[i])
    );
  end

  ils_reduce u_reduce (
    .clk_i (clk_i),
    .en_i  (state_q == ST_GRP),
    .hit_i (hit),
    .sel_i (sel),
    .red_o (red)
  );

  // Assembly of the result item from the held decode and the tree output.
  always_comb begin
    rd_ext         = $signed(red.rd);
    res.status     = pend_status_q;
    res.data       = '0;
    res.count      = POS_W'(count_q);
    res.empty_res  = (count_q == '0);
    res.found      = 1'b0;
    if (pend_err_q) begin
      res.data = ERR_DATA;
    end else if (pend_rd_q) begin
      res.data = rd_ext[WORD_W-1:0];
    end else if (pend_find_q) begin
      if (red.hit) begin
        res.data  = WORD_W'(red.idx);
        res.found = 1'b1;
      end else begin
        res.status = STAT_MISS;
        res.data   = ERR_DATA;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      req_q         <= '0;
      count_q       <= '0;
      out_valid_q   <= 1'b0;
      out_item_q    <= '0;
      pend_status_q <= STAT_OK;
      pend_err_q    <= 1'b0;
      pend_rd_q     <= 1'b0;
      pend_find_q   <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != ST_RES) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            req_q   <= in_item_i;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          count_q       <= count_d;
          pend_status_q <= pend_status_d;
          pend_err_q    <= pend_err_d;
          pend_rd_q     <= pend_rd_d;
          pend_find_q   <= pend_find_d;
          state_q       <= ST_GRP;
        end
        ST_GRP: begin
          state_q <= ST_RES;
        end
        ST_RES: begin
          if (!out_valid_q || !out_stall_i) begin
            out_item_q  <= res;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[hw/rtl/ils_checker.sv]
// Port-level checks on the indexed list store and the bind that attaches
// them. Depends on ils_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ils_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input ils_pkg::req_t in_item_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input ils_pkg::res_t out_item_o
);
  import ils_pkg::*;

  logic in_take, out_wait, out_found, empty_ok, found_ok;

  assign in_take   = in_valid_i && !in_stall_o;
  assign out_wait  = out_valid_o && out_stall_i;
  assign out_found = out_valid_o && out_item_o.found;
  assign empty_ok  = (out_item_o.empty_res == (out_item_o.count == '0));
  assign found_ok  = (out_item_o.status == STAT_OK) && (out_item_o.count != '0);

  // A request is served alone, so the input closes right after acceptance.
  `ILS_ASSERT(a_busy_after_accept, in_take |=> in_stall_o, "input not closed after an item")

  `ILS_ASSERT(a_out_hold, out_wait |=> out_valid_o && $stable(out_item_o), "stalled item changed")

  `ILS_ASSERT(a_empty_flag, out_valid_o |-> empty_ok, "empty flag disagrees with count")

  `ILS_ASSERT(a_found_ok, out_found |-> found_ok, "match reported with bad status or empty list")

  `ILS_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "result offered during reset")

endmodule

bind indexed_list_store ils_checker u_checker (.*);
